// File: rtl/mlm_pkg.sv
// shared constants, types and codes of the mutex lock manager
// no dependencies
package mlm_pkg;

  localparam int MUTEX_COUNT = 32;
  localparam int TASK_COUNT  = 64;
  localparam int MW          = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int TW          = 6;
  localparam logic [5:0] CNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DEADLOCK  = 3'd2;
  localparam logic [2:0] ST_NOTHOLDER = 3'd3;
  localparam logic [2:0] ST_NONEFREE  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_WREAD = 2'd2,
    S_WAKE  = 2'd3
  } state_t;

  typedef struct packed {
    logic       preempt;
    logic [5:0] wake_prio;
    logic [5:0] wake_task;
    logic       wake_valid;
    logic       demote;
    logic       promote;
    logic       must_sleep;
    logic       acquired;
    logic [4:0] created_id;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic          found;
    logic [MW-1:0] index;
  } free_t;

endpackage

// File: rtl/mutex_lock_manager.sv
// top level of the mutex lock manager: control sequencer and state memories
// depends on mlm_pkg and mlm_free_find
//
// usage
//   s_* channel carries one request: command, mutex id, task id and priority
//   m_* channel returns exactly one result per request, in request order
//   a request is taken only while the sequencer is idle; for every request
//   but an unlock that hands the mutex to a waiter, the request and its
//   memory reads are registered, EXEC builds the result into the output
//   register and the sequencer returns to idle; such an unlock goes on from
//   EXEC through WREAD (second read of the task memories at the woken task)
//   to WAKE, which builds the result and returns to idle
//   the cost is set by the registered reads of the per-mutex and
//   per-task memories, read, modified and written back in sequence
//   a finished result waits in the output register; a new request can be
//   accepted meanwhile, and its final step waits until that slot frees
//   reset: all mutexes free and unlocked, all queues empty, all held
//   counts zero (valid bits per task), no result pending
//   receiver stall: the result is held stable until m_tready
module mutex_lock_manager import mlm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], mutex_id[7:2], task_id[13:8], task_prio[19:14], zero pad
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], created_id[7:3], acquired[8], must_sleep[9], promote[10],
  // demote[11], wake_valid[12], wake_task[18:13], wake_prio[24:19],
  // preempt[25], zero pad
  output logic [31:0] m_tdata
);

  state_t state, state_next;

  // control flags in flip-flops
  logic [MUTEX_COUNT-1:0] allocated, locked, q_nonempty;
  logic [TASK_COUNT-1:0]  cnt_vld;

  // per-mutex memories
  logic [5:0] mem_holder [MUTEX_COUNT];
  logic [5:0] mem_head   [MUTEX_COUNT];
  logic [5:0] mem_tail   [MUTEX_COUNT];
  // per-task memories
  logic [5:0] mem_next   [TASK_COUNT];
  logic [5:0] mem_wprio  [TASK_COUNT];
  logic [5:0] mem_cnt    [TASK_COUNT];

  logic [5:0] rd_holder, rd_head, rd_tail, rd_next, rd_wprio, rd_cnt;
  logic       rd_cnt_vld;

  logic [1:0] cmd;
  logic [5:0] mid, tid, prio, w_task, tail_r;
  logic       demote_r;
  res_t       res, res_next;
  logic       out_valid, out_valid_next;

  logic           accept, proceed, m_valid, alloc_ok, is_holder;
  logic [MW-1:0]  mi;
  logic [TW-1:0]  task_rd_addr;
  logic [5:0]     cnt_val, cnt_inc, cnt_dec;
  free_t          free;

  mlm_free_find u_find (
    .allocated (allocated),
    .free      (free)
  );

  assign accept  = s_tvalid && s_tready;
  assign proceed = !out_valid || m_tready;
  assign mi      = mid[MW-1:0];
  assign m_valid = {1'b0, mid} < 7'(MUTEX_COUNT);
  assign alloc_ok  = m_valid && allocated[mi];
  assign is_holder = locked[mi] && (rd_holder == tid);
  assign cnt_val = rd_cnt_vld ? rd_cnt : 6'd0;
  assign cnt_inc = (cnt_val < CNT_MAX) ? cnt_val + 6'd1 : cnt_val;
  assign cnt_dec = (cnt_val > 6'd0) ? cnt_val - 6'd1 : cnt_val;
  // task ids alias modulo the task count, which is the full 6-bit range
  assign task_rd_addr = (state == S_WREAD) ? w_task : s_tdata[13:8];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if (proceed) begin
          if (cmd == CMD_UNLOCK && alloc_ok && is_holder && q_nonempty[mi])
            state_next = S_WREAD;
          else
            state_next = S_IDLE;
        end
      end
      S_WREAD: state_next = S_WAKE;
      S_WAKE:  if (proceed) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = out_valid;
    m_tdata  = {6'd0, res};
  end

  // result register next value
  always_comb begin
    res_next       = res;
    out_valid_next = out_valid && !m_tready;
    if (state == S_EXEC && proceed) begin
      res_next = '0;
      if (cmd == CMD_CREATE) begin
        out_valid_next = 1'b1;
        if (free.found) begin
          res_next.status     = ST_OK;
          res_next.created_id = 5'(free.index);
        end else begin
          res_next.status = ST_NONEFREE;
        end
      end else if (cmd == CMD_NONE || !alloc_ok) begin
        out_valid_next  = 1'b1;
        res_next.status = ST_INVALID;
      end else if (cmd == CMD_LOCK) begin
        out_valid_next = 1'b1;
        if (is_holder) begin
          res_next.status = ST_DEADLOCK;
        end else if (!locked[mi]) begin
          res_next.acquired = 1'b1;
          res_next.promote  = 1'b1;
        end else begin
          res_next.must_sleep = 1'b1;
        end
      end else begin
        if (!is_holder) begin
          out_valid_next  = 1'b1;
          res_next.status = ST_NOTHOLDER;
        end else begin
          res_next.demote = (cnt_dec == 6'd0);
          // with waiters the result is built in the wake step
          if (!q_nonempty[mi]) out_valid_next = 1'b1;
        end
      end
    end
    if (state == S_WAKE && proceed) begin
      out_valid_next      = 1'b1;
      res_next            = '0;
      res_next.status     = ST_OK;
      res_next.demote     = demote_r;
      res_next.wake_valid = 1'b1;
      res_next.wake_task  = w_task;
      res_next.wake_prio  = rd_wprio;
      res_next.preempt    = (rd_wprio < prio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // request capture and memory reads
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= s_tdata[1:0];
      mid  <= s_tdata[7:2];
      tid  <= s_tdata[13:8];
      prio <= s_tdata[19:14];
      rd_holder <= mem_holder[s_tdata[MW+1:2]];
      rd_head   <= mem_head[s_tdata[MW+1:2]];
      rd_tail   <= mem_tail[s_tdata[MW+1:2]];
    end
    if (accept || state == S_WREAD) begin
      rd_next    <= mem_next[task_rd_addr];
      rd_wprio   <= mem_wprio[task_rd_addr];
      rd_cnt     <= mem_cnt[task_rd_addr];
      rd_cnt_vld <= cnt_vld[task_rd_addr];
    end
  end

  // read-modify-write of the state
  always_ff @(posedge clk) begin
    if (rst) begin
      allocated  <= '0;
      locked     <= '0;
      q_nonempty <= '0;
      cnt_vld    <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      res       <= res_next;
      if (state == S_EXEC && proceed) begin
        if (cmd == CMD_CREATE) begin
          if (free.found) allocated[free.index] <= 1'b1;
        end else if (cmd == CMD_NONE || !alloc_ok) begin
          // invalid request: nothing changes
        end else if (cmd == CMD_LOCK) begin
          if (is_holder) begin
            // deadlock: nothing changes
          end else if (!locked[mi]) begin
            // free mutex: grant at once
            locked[mi]     <= 1'b1;
            mem_holder[mi] <= tid;
            mem_cnt[tid]   <= cnt_inc;
            cnt_vld[tid]   <= 1'b1;
          end else begin
            // held by another task: append to the waiter fifo
            mem_wprio[tid] <= prio;
            if (q_nonempty[mi]) begin
              mem_next[rd_tail] <= tid;
            end else begin
              mem_head[mi]   <= tid;
              q_nonempty[mi] <= 1'b1;
            end
            mem_tail[mi] <= tid;
          end
        end else begin
          if (is_holder) begin
            mem_cnt[tid] <= cnt_dec;
            cnt_vld[tid] <= 1'b1;
            demote_r     <= (cnt_dec == 6'd0);
            w_task       <= rd_head;
            tail_r       <= rd_tail;
            if (!q_nonempty[mi]) locked[mi] <= 1'b0;
          end
        end
      end
      if (state == S_WAKE && proceed) begin
        // hand the mutex to the head waiter
        if (w_task == tail_r) q_nonempty[mi] <= 1'b0;
        else                  mem_head[mi]   <= rd_next;
        mem_holder[mi]  <= w_task;
        mem_cnt[w_task] <= cnt_inc;
        cnt_vld[w_task] <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/mlm_free_find.sv
// lowest free mutex search over the allocation bits
// depends on mlm_pkg
module mlm_free_find import mlm_pkg::*; (
  input  logic [MUTEX_COUNT-1:0] allocated,
  output free_t                  free
);

  always_comb begin
    free = '0;
    for (int i = MUTEX_COUNT - 1; i >= 0; i--) begin
      if (!allocated[i]) begin
        free.found = 1'b1;
        free.index = MW'(i);
      end
    end
  end

endmodule

// File: rtl/mlm_checker.sv
// port-level checks for the mutex lock manager, bound to the top level
// depends on mutex_lock_manager
module mlm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another in work");

  // no result appears straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  // status code within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'd4)
    else $error("undefined status code");

  // stalled result held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind mutex_lock_manager mlm_port_checks u_mlm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
